// ----- hdl/psp_pkg.sv -----
// shared constants, codes and types of the pcm sample player
`timescale 1ns / 1ps
package psp_pkg;

  localparam int STORE_DEPTH_DEF  = 65536;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = 16;
  localparam int CHCNT_W    = 4;
  localparam int RATE_W     = 24;
  localparam int TOTAL_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int POS_W      = 32;
  localparam int PROD_W     = 40;
  localparam int Q_DEPTH    = 4;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT,
    CFG_RATE_RATIO,
    CFG_LOOP_ENABLE,
    CFG_SAMPLE_TOTAL
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_REWIND,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic [CHCNT_W-1:0] chans;
    logic [RATE_W-1:0]  rate;
    logic               loop_en;
    logic [TOTAL_W-1:0] total;
  } cfg_t;

endpackage

// ----- hdl/psp_if.sv -----
// channel interfaces: request input, mono result output, configuration write
`timescale 1ns / 1ps
interface psp_in_if import psp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [ADDR_W-1:0]          sample_address;
  logic signed [SAMPLE_W-1:0] sample_value;
  modport source (output valid, req_type, sample_address, sample_value, input ready);
  modport sink (input valid, req_type, sample_address, sample_value, output ready);
endinterface

interface psp_out_if import psp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] audio_out;
  logic                       active;
  modport source (output valid, audio_out, active, input ready);
  modport sink (input valid, audio_out, active, output ready);
endinterface

interface psp_cfg_if import psp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/psp_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module psp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/psp_front.sv -----
// front end: takes request beats, classifies them and queues them for the back end
`timescale 1ns / 1ps
module psp_front import psp_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  psp_in_if.sink    in_bus,
  output q_entry_t  q_head,
  output logic      q_valid,
  input  logic      q_pop
);

  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  q_entry_t         q_mem_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   count_r;
  q_entry_t         entry;
  logic             push;
  logic             pop;

  assign in_bus.ready = (count_r != QCW'(Q_DEPTH));
  assign push         = in_bus.valid && in_bus.ready;
  assign q_valid      = (count_r != '0);
  assign pop          = q_pop && q_valid;
  assign q_head       = q_mem_r[rd_ptr_r];

  // writes beyond the store only rewind playback
  always_comb begin
    entry.addr  = in_bus.sample_address;
    entry.value = in_bus.sample_value;
    if (in_bus.req_type == REQ_TICK) begin
      entry.op = OP_TICK;
    end else if (32'(in_bus.sample_address) < STORE_DEPTH) begin
      entry.op = OP_STORE;
    end else begin
      entry.op = OP_REWIND;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/psp_back.sv -----
// back end: store writes, frame position math, channel sum and serial divide
`timescale 1ns / 1ps
module psp_back import psp_pkg::*; #(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  q_entry_t                   q_head,
  input  logic                       q_valid,
  output logic                       q_pop,
  output logic                       ram_we,
  output logic [$clog2(STORE_DEPTH)-1:0] ram_waddr,
  output logic [SAMPLE_W-1:0]        ram_wdata,
  output logic                       ram_re,
  output logic [$clog2(STORE_DEPTH)-1:0] ram_raddr,
  input  logic [SAMPLE_W-1:0]        ram_rdata,
  psp_out_if.source                  out_bus
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CHW = $clog2(MAX_CHANNELS + 1);
  localparam int SW  = SAMPLE_W + $clog2(MAX_CHANNELS) + 1;
  localparam int IW  = TOTAL_W + CHW;
  localparam int DCW = $clog2(SW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_FRAME,
    S_IDX,
    S_CHK,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  state_t                  state_r;
  logic [POS_W-1:0]        position_r;
  logic [PROD_W-1:0]       prod_lo_r;
  logic [PROD_W-1:0]       prod_hi_r;
  logic [TOTAL_W-1:0]      frame_lo_r;
  logic                    frame_big_r;
  logic [IW-1:0]           idx_r;
  logic [TOTAL_W-1:0]      base_r;
  logic [CHW-1:0]          n_r;
  logic [CHW-1:0]          cnt_r;
  logic                    pend_r;
  logic signed [SW-1:0]    sum_r;
  logic                    neg_r;
  logic [SW-1:0]           dq_r;
  logic [CHW-1:0]          rem_r;
  logic [DCW-1:0]          div_cnt_r;
  logic [SAMPLE_W-1:0]     res_audio_r;
  logic                    res_active_r;
  logic                    out_valid_r;
  logic [SAMPLE_W-1:0]     out_audio_r;
  logic                    out_active_r;

  logic [CHW-1:0]          chans_eff;
  logic [TOTAL_W-1:0]      total_eff;
  logic [15:0]             mul_a;
  logic [PROD_W-1:0]       mul_p;
  logic [PROD_W-1:0]       frame;
  logic                    past;
  logic [TOTAL_W-1:0]      base;
  logic [TOTAL_W-1:0]      remaining;
  logic [POS_W-1:0]        pos_new;
  logic [SW-1:0]           mag;
  logic [CHW:0]            rem_sh;
  logic                    qbit;
  logic [CHW:0]            rem_sub;
  logic [SW-1:0]           dq_step;
  logic [SW-1:0]           q_signed;

  always_comb begin
    if (cfg.chans == '0) begin
      chans_eff = CHW'(1);
    end else if (32'(cfg.chans) > MAX_CHANNELS) begin
      chans_eff = CHW'(MAX_CHANNELS);
    end else begin
      chans_eff = CHW'(cfg.chans);
    end
    if (32'(cfg.total) > STORE_DEPTH) begin
      total_eff = TOTAL_W'(STORE_DEPTH);
    end else begin
      total_eff = cfg.total;
    end
  end

  // one 16x24 multiplier shared by both halves of the position
  assign mul_a = (state_r == S_MUL_LO) ? position_r[15:0] : position_r[31:16];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(cfg.rate);
  assign frame = prod_hi_r + PROD_W'(prod_lo_r[PROD_W-1:16]);

  assign past      = frame_big_r || (idx_r >= IW'(total_eff));
  assign base      = past ? '0 : idx_r[TOTAL_W-1:0];
  assign remaining = total_eff - base;
  assign pos_new   = (past ? '0 : position_r) + 1'b1;

  assign mag      = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign rem_sh   = {rem_r, dq_r[SW-1]};
  assign qbit     = (rem_sh >= {1'b0, chans_eff});
  assign rem_sub  = qbit ? (rem_sh - {1'b0, chans_eff}) : rem_sh;
  assign dq_step  = {dq_r[SW-2:0], qbit};
  assign q_signed = neg_r ? (~dq_step + 1'b1) : dq_step;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign ram_we    = q_pop && (q_head.op == OP_STORE);
  assign ram_waddr = AW'(q_head.addr);
  assign ram_wdata = q_head.value;
  assign ram_re    = (state_r == S_SUM) && (cnt_r < n_r);
  assign ram_raddr = AW'(base_r + TOTAL_W'(cnt_r));

  assign out_bus.valid     = out_valid_r;
  assign out_bus.audio_out = out_audio_r;
  assign out_bus.active    = out_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      position_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (out_valid_r && out_bus.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_head.op)
              OP_STORE, OP_REWIND: begin
                position_r <= '0;
              end
              OP_TICK: begin
                if (total_eff == '0) begin
                  res_audio_r  <= '0;
                  res_active_r <= 1'b0;
                  state_r      <= S_OUT;
                end else begin
                  state_r <= S_MUL_LO;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL_LO: begin
          prod_lo_r <= mul_p;
          state_r   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi_r <= mul_p;
          state_r   <= S_FRAME;
        end
        S_FRAME: begin
          frame_lo_r  <= frame[TOTAL_W-1:0];
          frame_big_r <= |frame[PROD_W-1:TOTAL_W];
          state_r     <= S_IDX;
        end
        S_IDX: begin
          idx_r   <= IW'(frame_lo_r) * IW'(chans_eff);
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (past && !cfg.loop_en) begin
            res_audio_r  <= '0;
            res_active_r <= (POS_W'(total_eff) > position_r);
            state_r      <= S_OUT;
          end else begin
            // partial last frame sums only the samples below the sample total
            base_r       <= base;
            n_r          <= (remaining < TOTAL_W'(chans_eff)) ? CHW'(remaining) : chans_eff;
            cnt_r        <= '0;
            pend_r       <= 1'b0;
            sum_r        <= '0;
            position_r   <= pos_new;
            res_active_r <= cfg.loop_en || (pos_new < POS_W'(total_eff));
            state_r      <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt_r < n_r) begin
            cnt_r <= cnt_r + 1'b1;
          end
          pend_r <= (cnt_r < n_r);
          if (pend_r) begin
            sum_r <= sum_r + SW'($signed(ram_rdata));
          end
          if ((cnt_r == n_r) && !pend_r) begin
            neg_r     <= sum_r[SW-1];
            dq_r      <= mag;
            rem_r     <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          dq_r      <= dq_step;
          rem_r     <= rem_sub[CHW-1:0];
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DCW'(SW - 1)) begin
            res_audio_r <= q_signed[SAMPLE_W-1:0];
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r  <= 1'b1;
            out_audio_r  <= res_audio_r;
            out_active_r <= res_active_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/pcm_sample_player_resample_downmix.sv -----
// top level of the pcm sample player: configuration registers and block wiring
//
// in_bus carries request beats: req_type 0 stores sample_value at
// sample_address and rewinds playback, req_type 1 is one output tick.
// out_bus returns one beat per tick (none per store write): the mono
// downmix of the source frame floor(position * rate_ratio / 2^16) and the
// active flag. cfg_bus writes channel_count, rate_ratio, loop_enable and
// sample_total by index and is always ready; the user is to write it only
// while idle, which the block itself does not enforce. A four-entry queue
// sits between the request side and the engine, so requests keep flowing
// while a result waits on out_bus. A tick goes from the queue head through
// pop, position multiply and index setup, a read of the channels summed
// through the store's one registered read port, the bit-serial divider by
// the channel count, and the load of the output register. Ticks run one
// at a time: the engine takes no new request until the last result is in
// the output register. Reset clears the queue, the play position and the
// output; the sample store keeps its contents. When the receiver stalls
// the result holds on out_bus and the engine waits with the next tick's
// result.
`timescale 1ns / 1ps
module pcm_sample_player_resample_downmix import psp_pkg::*; #(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  psp_in_if.sink     in_bus,
  psp_out_if.source  out_bus,
  psp_cfg_if.sink    cfg_bus
);

  localparam int AW = $clog2(STORE_DEPTH);

  cfg_t                cfg_r;
  q_entry_t            q_head;
  logic                q_valid;
  logic                q_pop;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chans   <= CHCNT_W'(1);
      cfg_r.rate    <= RATE_W'(65536);
      cfg_r.loop_en <= 1'b1;
      cfg_r.total   <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_idx_t'(cfg_bus.index))
        CFG_CHANNEL_COUNT: cfg_r.chans   <= cfg_bus.data[CHCNT_W-1:0];
        CFG_RATE_RATIO:    cfg_r.rate    <= cfg_bus.data[RATE_W-1:0];
        CFG_LOOP_ENABLE:   cfg_r.loop_en <= cfg_bus.data[0];
        CFG_SAMPLE_TOTAL:  cfg_r.total   <= cfg_bus.data[TOTAL_W-1:0];
      endcase
    end
  end

  psp_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  psp_back #(
    .STORE_DEPTH  (STORE_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_head    (q_head),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_bus   (out_bus)
  );

  psp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- hdl/psp_checker.sv -----
// port-level assertions for the pcm sample player, bound to the top level
`timescale 1ns / 1ps
module psp_checker (
  input logic       clk,
  input logic       rst_n,
  psp_in_if.sink    in_bus,
  psp_out_if.source out_bus,
  psp_cfg_if.sink   cfg_bus
);

  // a stalled result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |=>
      out_bus.valid && $stable(out_bus.audio_out) && $stable(out_bus.active))
    else $error("result beat changed while stalled");

  // reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result valid right after reset");

  // configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_bus.ready)
    else $error("configuration port not ready");

  // a result beat never carries unknown bits
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !$isunknown({out_bus.audio_out, out_bus.active}))
    else $error("result beat with unknown bits");

endmodule

bind pcm_sample_player_resample_downmix psp_checker u_psp_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_bus  (in_bus),
  .out_bus (out_bus),
  .cfg_bus (cfg_bus)
);

// ----- verif/testbench.sv -----
// self-checking testbench for the pcm sample player: store writes, ticks, downmix and looping
`timescale 1ns / 1ps
module testbench import psp_pkg::*; ();

  localparam int BLOCK_LATENCY = 60;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 85;

  typedef struct {
    logic                       kind;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] value;
  } request_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] audio;
    logic                       active;
  } mix_t;

  logic clk;
  logic rst_n;

  psp_in_if  in_if ();
  psp_out_if out_if ();
  psp_cfg_if cfg_if ();

  pcm_sample_player_resample_downmix uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // register copies, shared by the stimulus planner and the predictor
  logic [CHCNT_W-1:0] reg_chans = 4'd1;
  logic [RATE_W-1:0]  reg_rate  = 24'h010000;
  logic               reg_loop  = 1'b1;
  logic [TOTAL_W-1:0] reg_total = '0;

  logic signed [SAMPLE_W-1:0] sample_mem [STORE_DEPTH_DEF];
  bit                         loaded [STORE_DEPTH_DEF];
  logic [POS_W-1:0]           play_pos = '0;
  logic [POS_W-1:0]           plan_pos = '0;

  request_t request_queue [$];
  mix_t     expected_mix [$];
  request_t cur_req;
  mix_t     want;
  bit       in_busy = 1'b0;

  int errors         = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_left   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // read span and next position of one tick under the current registers
  function automatic void plan_tick(input logic [POS_W-1:0] pos,
                                    output logic [POS_W-1:0] pos_next,
                                    output int unsigned first, output int unsigned count,
                                    output int unsigned chans, output logic live);
    longint unsigned p, total, frame, idx;
    logic [POS_W-1:0] cur;
    chans = (reg_chans == 0) ? 1 :
            (reg_chans > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : 32'(reg_chans);
    total = (reg_total > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : 64'(reg_total);
    cur = pos;
    pos_next = pos;
    first = 0;
    count = 0;
    live = 1'b0;
    if (total == 0) return;
    p = 64'(pos);
    frame = (p * 64'(reg_rate)) >> 16;
    idx = frame * 64'(chans);
    if (idx >= total) begin
      if (!reg_loop) begin
        live = (p < total);
        return;
      end
      cur = '0;
      idx = 0;
    end
    first = 32'(idx);
    count = 32'((total - idx < 64'(chans)) ? total - idx : 64'(chans));
    pos_next = cur + 1'b1;
    live = reg_loop || (64'(pos_next) < total);
  endfunction

  function automatic void apply_request(input request_t rq);
    logic [POS_W-1:0] nxt;
    int unsigned first, count, chans;
    logic live;
    int sum;
    int mixed;
    mix_t res;
    if (rq.kind == REQ_WRITE) begin
      sample_mem[rq.addr] = rq.value;
      play_pos = '0;
      return;
    end
    plan_tick(play_pos, nxt, first, count, chans, live);
    sum = 0;
    for (int unsigned i = 0; i < count; i++) sum += int'(sample_mem[first + i]);
    mixed = sum / int'(chans);
    res.audio = mixed[SAMPLE_W-1:0];
    res.active = live;
    expected_mix.push_back(res);
    play_pos = nxt;
  endfunction

  function automatic void queue_write(input logic [ADDR_W-1:0] addr,
                                      input logic [SAMPLE_W-1:0] value);
    request_t rq;
    rq.kind = REQ_WRITE;
    rq.addr = addr;
    rq.value = value;
    request_queue.push_back(rq);
    loaded[addr] = 1'b1;
    plan_pos = '0;
  endfunction

  // a tick that would read a never-written entry gets that entry written first
  function automatic void queue_tick();
    logic [POS_W-1:0] nxt;
    int unsigned first, count, chans;
    logic live;
    bit fresh;
    request_t rq;
    do begin
      fresh = 1'b0;
      plan_tick(plan_pos, nxt, first, count, chans, live);
      for (int unsigned i = 0; i < count; i++) begin
        if (!loaded[first + i]) begin
          queue_write(ADDR_W'(first + i), SAMPLE_W'($urandom));
          fresh = 1'b1;
        end
      end
    end while (fresh);
    rq.kind = REQ_TICK;
    rq.addr = ADDR_W'($urandom);
    rq.value = SAMPLE_W'($urandom);
    request_queue.push_back(rq);
    plan_pos = nxt;
  endfunction

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_CHANNEL_COUNT: reg_chans = d[CHCNT_W-1:0];
      CFG_RATE_RATIO:    reg_rate = d[RATE_W-1:0];
      CFG_LOOP_ENABLE:   reg_loop = d[0];
      CFG_SAMPLE_TOTAL:  reg_total = d[TOTAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // unused upper data bits carry noise
  task automatic configure(input logic [CHCNT_W-1:0] ch, input logic [RATE_W-1:0] rate,
                           input logic lp, input logic [TOTAL_W-1:0] tot);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[CHCNT_W-1:0] = ch;
    write_cfg(CFG_CHANNEL_COUNT, d);
    write_cfg(CFG_RATE_RATIO, rate);
    d = CFG_DATA_W'($urandom);
    d[0] = lp;
    write_cfg(CFG_LOOP_ENABLE, d);
    d = CFG_DATA_W'($urandom);
    d[TOTAL_W-1:0] = tot;
    write_cfg(CFG_SAMPLE_TOTAL, d);
  endtask

  task automatic settle();
    while (request_queue.size() != 0 || in_busy || expected_mix.size() != 0)
      @(posedge clk);
    repeat (BLOCK_LATENCY) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_busy) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = request_queue.pop_front();
        in_if.req_type <= cur_req.kind;
        in_if.sample_address <= cur_req.addr;
        in_if.sample_value <= cur_req.value;
        in_if.valid <= 1'b1;
        in_busy = 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_if.ready <= 1'b0;
      holdoff_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        apply_request(cur_req);
        in_busy = 1'b0;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_mix.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected: audio_out %0d active %0b",
                   $time, out_if.audio_out, out_if.active);
        end else begin
          want = expected_mix.pop_front();
          if (out_if.audio_out !== want.audio) begin
            errors++;
            $display("%0t: audio_out expected %0d got %0d",
                     $time, want.audio, out_if.audio_out);
          end
          if (out_if.active !== want.active) begin
            errors++;
            $display("%0t: active expected %0b got %0b", $time, want.active, out_if.active);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [CHCNT_W-1:0] ch;
    logic [RATE_W-1:0]  rate;
    logic               lp;
    logic [TOTAL_W-1:0] tot;
    int                 span;
    int                 base;
    int                 n;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_WRITE;
    in_if.sample_address = '0;
    in_if.sample_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_CHANNEL_COUNT;
    cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty store under reset registers, then field extremes
    queue_tick();
    queue_write(16'd65535, 16'h7fff);
    queue_write(16'd0, 16'h8000);
    queue_write(16'd1, 16'h7fff);
    queue_write(16'd2, 16'sd12345);
    queue_write(16'd3, -16'sd7);
    queue_write(16'd4, -16'sd20000);
    settle();
    // three channels, partial last frame, then silence past the end
    configure(4'd3, 24'h010000, 1'b0, 17'd5);
    repeat (4) queue_tick();
    settle();
    // zero channels and zero rate, total beyond the store
    configure(4'd0, 24'h000000, 1'b1, 17'h1ffff);
    repeat (2) queue_tick();
    settle();
    // channel count above max, fastest rate, wrap to start
    configure(4'd15, 24'hffffff, 1'b1, 17'd2);
    repeat (3) queue_tick();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (p == 0) begin
        ch = 4'd8; rate = 24'h010000; lp = 1'b1; tot = 17'd64;
      end else if (p == 1) begin
        ch = 4'd1; rate = 24'd1; lp = 1'b0; tot = 17'd65536;
      end else if (p == 2) begin
        ch = 4'd5; rate = 24'h018000; lp = 1'b0; tot = 17'd37;
      end else begin
        ch = CHCNT_W'(($urandom_range(15) < 12) ? $urandom_range(1, 8) :
                                                   $urandom_range(15));
        case ($urandom_range(7))
          0: rate = 24'h010000;
          1: rate = RATE_W'($urandom_range(1, 65535));
          2: rate = RATE_W'($urandom_range(65536, 262144));
          3: rate = '0;
          4: rate = 24'hffffff;
          5: rate = RATE_W'($urandom);
          default: rate = RATE_W'($urandom_range(16384, 131072));
        endcase
        lp = 1'($urandom_range(1));
        case ($urandom_range(7))
          0: tot = '0;
          1: tot = 17'd65536;
          2: tot = TOTAL_W'($urandom_range(65537, 131071));
          3: tot = TOTAL_W'($urandom_range(1, 4096));
          default: tot = TOTAL_W'($urandom_range(1, 200));
        endcase
      end
      configure(ch, rate, lp, tot);
      if (p == 0 || p == 8) holdoff_left = 400;

      span = (tot > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : int'(tot);
      if (span > 256) span = 256;
      // load a run of samples, then mostly play it back
      if (span > 0) begin
        base = int'($urandom_range(span - 1));
        n = int'($urandom_range(4, 16));
        for (int k = 0; k < n; k++) queue_write(ADDR_W'(base + k), SAMPLE_W'($urandom));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 12) begin
          if (span > 0 && $urandom_range(9) < 7)
            queue_write(ADDR_W'($urandom_range(span - 1)), SAMPLE_W'($urandom));
          else
            queue_write(ADDR_W'($urandom_range(65535)), SAMPLE_W'($urandom));
        end else begin
          queue_tick();
        end
      end
    end

    while (request_queue.size() != 0 || in_busy || expected_mix.size() != 0)
      @(posedge clk);
    repeat (BLOCK_LATENCY) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/psp_pkg.sv
hdl/psp_if.sv
hdl/psp_ram.sv
hdl/psp_front.sv
hdl/psp_back.sv
hdl/pcm_sample_player_resample_downmix.sv
hdl/psp_checker.sv
verif/testbench.sv
